@@ rtl/dtas_pkg.sv @@
// shared types, register indexes and constants for the digital-to-analog slider
package dtas_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_IS_AXIS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SPEED      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_RATE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELATIVE_OUTPUT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN     = 3'd4;

    localparam logic        RST_SOURCE_IS_AXIS  = 1'b0;
    localparam logic [15:0] RST_STEP_SPEED      = 16'd1792;
    localparam logic [7:0]  RST_CENTRE_RATE     = 8'd0;
    localparam logic        RST_RELATIVE_OUTPUT = 1'b0;
    localparam logic [9:0]  RST_OUTPUT_GAIN     = 10'd256;

    localparam logic [15:0] CENTRE_POS   = 16'h8000;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [8:0]  KEY_STEP_MAG = 9'd256;
    localparam logic [15:0] GAME_MAX     = 16'h7FFF;
    localparam logic [15:0] GAME_MIN     = 16'h8000;

    typedef struct packed {
        logic               key_decrease;
        logic               key_increase;
        logic signed [15:0] axis_sample;
    } dtas_in_t;

    typedef struct packed {
        logic [15:0] position;
        logic [15:0] game_value;
    } dtas_out_t;

endpackage

@@ rtl/digital_to_analog_slider_core.sv @@
// digital-to-analog slider core: bit-serial step, centring and output scaling
//
// usage:
//   in_valid/in_ready carry one item per frame: two key bits and a signed axis sample.
//   out_valid/out_ready carry one result per item: new position and clipped game value.
//   cfg_we/cfg_index/cfg_data write the five settings; write only while the block is idle.
// sequence:
//   an item runs shift-add step scaling alongside a restoring divide for the centring
//   decay, then an add and saturate step, a step to set up the output multiply and
//   shift-add output gain, then passes into the output register; the block takes
//   no new item until it is back in idle, so items are not overlapped.
//   the 16-bit divider and the 10-bit gain multiplier set the length of this sequence.
// reset:
//   position returns to 0x8000 and the settings to their defaults; no result pending.
// stall:
//   a result waits in the output register while out_ready is low; the next item is
//   accepted and processed, then holds in its last step until the register is free.
module digital_to_analog_slider_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  dtas_pkg::dtas_in_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output dtas_pkg::dtas_out_t                    out_data,
    input  logic                                   cfg_we,
    input  logic [dtas_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [dtas_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import dtas_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC  = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_GINIT = 3'd3;
    localparam logic [2:0] ST_GMUL  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [3:0] CALC_LAST = 4'd15;
    localparam logic [3:0] GMUL_LAST = 4'd9;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] pos_reg, pos_next;
    logic        out_valid_reg, out_valid_next;
    dtas_out_t   out_reg, out_next;

    logic        source_is_axis_reg;
    logic [15:0] step_speed_reg;
    logic [7:0]  centre_rate_reg;
    logic        relative_output_reg;
    logic [9:0]  output_gain_reg;

    logic [23:0] smul_acc_reg, smul_acc_next;
    logic [23:0] smul_mcand_reg, smul_mcand_next;
    logic [8:0]  smul_mplier_reg, smul_mplier_next;
    logic        step_neg_reg, step_neg_next;
    logic        active_reg, active_next;
    logic [7:0]  div_rem_reg, div_rem_next;
    logic [15:0] div_q_reg, div_q_next;
    logic [15:0] cmag_reg, cmag_next;
    logic        vneg_reg, vneg_next;
    logic [26:0] gmul_acc_reg, gmul_acc_next;
    logic [26:0] gmul_mcand_reg, gmul_mcand_next;
    logic [9:0]  gmul_mplier_reg, gmul_mplier_next;

    logic        in_fire;
    logic [15:0] axis_u;
    logic [15:0] axis_abs;
    logic [8:0]  load_mag;
    logic        load_neg;
    logic        load_active;
    logic [15:0] load_cmag;
    logic [8:0]  div_trial;
    logic        div_bit;
    logic [15:0] decay_mag;
    logic [15:0] centred_pos;
    logic [15:0] base_pos;
    logic [17:0] step_ext;
    logic [17:0] pos_sum;
    logic [15:0] pos_sat;
    logic [15:0] rel_pos;
    logic [16:0] g_val;
    logic [18:0] g_shift;
    logic [15:0] g_clip;
    logic        out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // source decode and centre offset at load
    assign axis_u      = in_data.axis_sample;
    assign axis_abs    = axis_u[15] ? (16'd0 - axis_u) : axis_u;
    assign load_mag    = source_is_axis_reg ? axis_abs[15:7]
                       : ((in_data.key_decrease ^ in_data.key_increase) ? KEY_STEP_MAG : 9'd0);
    assign load_neg    = source_is_axis_reg ? axis_u[15]
                       : (in_data.key_decrease && !in_data.key_increase);
    assign load_active = source_is_axis_reg ? (axis_u != 16'd0)
                       : (in_data.key_decrease || in_data.key_increase);
    assign load_cmag   = pos_reg[15] ? {1'b0, pos_reg[14:0]} : (CENTRE_POS - pos_reg);

    // restoring divide, one quotient bit a cycle
    assign div_trial = {div_rem_reg, div_q_reg[15]};
    assign div_bit   = (div_trial >= {1'b0, centre_rate_reg});

    // decay: floor(x * (n-1) / n) = x - ceil(x / n)
    assign decay_mag   = cmag_reg - div_q_reg - {15'd0, (div_rem_reg != 8'd0)};
    assign centred_pos = vneg_reg ? (CENTRE_POS - decay_mag) : (CENTRE_POS + decay_mag);
    assign base_pos    = ((centre_rate_reg != 8'd0) && !active_reg)
                       ? ((centre_rate_reg == 8'd1) ? CENTRE_POS : centred_pos)
                       : pos_reg;
    assign step_ext    = step_neg_reg ? (18'd0 - {2'b00, smul_acc_reg[23:8]})
                                      : {2'b00, smul_acc_reg[23:8]};
    assign pos_sum     = {2'b00, base_pos} + step_ext;
    assign pos_sat     = pos_sum[17] ? 16'd0 : (pos_sum[16] ? POS_MAX : pos_sum[15:0]);

    // game value source and clip
    assign rel_pos = pos_reg ^ CENTRE_POS;
    assign g_val   = relative_output_reg ? {{5{rel_pos[15]}}, rel_pos[15:4]}
                                         : {1'b0, pos_reg};
    assign g_shift = gmul_acc_reg[26:8];
    always_comb
    begin
        if (!g_shift[18] && (g_shift[17:15] != 3'b000))
        begin
            g_clip = GAME_MAX;
        end
        else if (g_shift[18] && (g_shift[17:15] != 3'b111))
        begin
            g_clip = GAME_MIN;
        end
        else
        begin
            g_clip = g_shift[15:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pos_next         = pos_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_next         = out_reg;
        smul_acc_next    = smul_acc_reg;
        smul_mcand_next  = smul_mcand_reg;
        smul_mplier_next = smul_mplier_reg;
        step_neg_next    = step_neg_reg;
        active_next      = active_reg;
        div_rem_next     = div_rem_reg;
        div_q_next       = div_q_reg;
        cmag_next        = cmag_reg;
        vneg_next        = vneg_reg;
        gmul_acc_next    = gmul_acc_reg;
        gmul_mcand_next  = gmul_mcand_reg;
        gmul_mplier_next = gmul_mplier_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    smul_acc_next    = 24'd0;
                    smul_mcand_next  = {8'd0, step_speed_reg};
                    smul_mplier_next = load_mag;
                    step_neg_next    = load_neg;
                    active_next      = load_active;
                    div_rem_next     = 8'd0;
                    div_q_next       = load_cmag;
                    cmag_next        = load_cmag;
                    vneg_next        = !pos_reg[15];
                    cnt_next         = CALC_LAST;
                    state_next       = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (smul_mplier_reg[0])
                begin
                    smul_acc_next = smul_acc_reg + smul_mcand_reg;
                end
                smul_mcand_next  = {smul_mcand_reg[22:0], 1'b0};
                smul_mplier_next = {1'b0, smul_mplier_reg[8:1]};
                div_rem_next     = div_bit ? (div_trial[7:0] - centre_rate_reg) : div_trial[7:0];
                div_q_next       = {div_q_reg[14:0], div_bit};
                cnt_next         = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                pos_next   = pos_sat;
                state_next = ST_GINIT;
            end
            ST_GINIT:
            begin
                gmul_acc_next    = 27'd0;
                gmul_mcand_next  = {{10{g_val[16]}}, g_val};
                gmul_mplier_next = output_gain_reg;
                cnt_next         = GMUL_LAST;
                state_next       = ST_GMUL;
            end
            ST_GMUL:
            begin
                if (gmul_mplier_reg[0])
                begin
                    gmul_acc_next = gmul_acc_reg + gmul_mcand_reg;
                end
                gmul_mcand_next  = {gmul_mcand_reg[25:0], 1'b0};
                gmul_mplier_next = {1'b0, gmul_mplier_reg[9:1]};
                cnt_next         = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next.position   = pos_reg;
                    out_next.game_value = g_clip;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            cnt_reg             <= 4'd0;
            pos_reg             <= CENTRE_POS;
            out_valid_reg       <= 1'b0;
            source_is_axis_reg  <= RST_SOURCE_IS_AXIS;
            step_speed_reg      <= RST_STEP_SPEED;
            centre_rate_reg     <= RST_CENTRE_RATE;
            relative_output_reg <= RST_RELATIVE_OUTPUT;
            output_gain_reg     <= RST_OUTPUT_GAIN;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOURCE_IS_AXIS:  source_is_axis_reg  <= cfg_data[0];
                    REG_STEP_SPEED:      step_speed_reg      <= cfg_data;
                    REG_CENTRE_RATE:     centre_rate_reg     <= cfg_data[7:0];
                    REG_RELATIVE_OUTPUT: relative_output_reg <= cfg_data[0];
                    REG_OUTPUT_GAIN:     output_gain_reg     <= cfg_data[9:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg         <= out_next;
        smul_acc_reg    <= smul_acc_next;
        smul_mcand_reg  <= smul_mcand_next;
        smul_mplier_reg <= smul_mplier_next;
        step_neg_reg    <= step_neg_next;
        active_reg      <= active_next;
        div_rem_reg     <= div_rem_next;
        div_q_reg       <= div_q_next;
        cmag_reg        <= cmag_next;
        vneg_reg        <= vneg_next;
        gmul_acc_reg    <= gmul_acc_next;
        gmul_mcand_reg  <= gmul_mcand_next;
        gmul_mplier_reg <= gmul_mplier_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("block still ready after taking an item");

    a_pos_only_in_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ADD) |=> $stable(pos_reg))
        else $error("position changed outside the update step");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a finished item");
`endif

endmodule

@@ sim/dtas_checker.sv @@
`timescale 1ns / 100ps
// checker: predicts slider position and game value for each item and compares results
module dtas_checker
    import dtas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  dtas_in_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  dtas_out_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_count,
    output int                     expected_left
);

    logic        axis_mode;
    logic [15:0] speed;
    logic [7:0]  centre_rate;
    logic        relative_mode;
    logic [9:0]  gain;
    logic [15:0] slider_pos;
    int          errors;
    dtas_out_t   expected_q[$];

    function automatic dtas_out_t advance_slider(input dtas_in_t item);
        longint    step_amt;
        longint    pos;
        longint    offset;
        longint    game;
        logic      active;
        dtas_out_t res;
        step_amt = 0;
        active   = 1'b0;
        pos      = longint'(slider_pos);
        if (axis_mode)
        begin
            active   = (item.axis_sample != 16'sd0);
            step_amt = longint'($signed(item.axis_sample)) / 128;
        end
        else
        begin
            if (item.key_decrease)
            begin
                active   = 1'b1;
                step_amt = step_amt - longint'(KEY_STEP_MAG);
            end
            if (item.key_increase)
            begin
                active   = 1'b1;
                step_amt = step_amt + longint'(KEY_STEP_MAG);
            end
        end
        step_amt = step_amt * longint'(speed) / 256;
        if (centre_rate != 8'd0 && !active)
        begin
            if (centre_rate == 8'd1)
                pos = longint'(CENTRE_POS);
            else
            begin
                offset = pos - longint'(CENTRE_POS);
                offset = offset * (longint'(centre_rate) - 1) / longint'(centre_rate);
                pos    = offset + longint'(CENTRE_POS);
            end
        end
        pos = pos + step_amt;
        if (pos < 0)
            pos = 0;
        if (pos > longint'(POS_MAX))
            pos = longint'(POS_MAX);
        game = pos;
        if (relative_mode)
            game = (game - longint'(CENTRE_POS)) >>> 4;
        game = (game * longint'(gain)) >>> 8;
        if (game < -longint'(GAME_MIN))
            game = -longint'(GAME_MIN);
        if (game > longint'(GAME_MAX))
            game = longint'(GAME_MAX);
        res.position   = pos[15:0];
        res.game_value = game[15:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        dtas_out_t want;
        if (!rst_n)
        begin
            axis_mode     = RST_SOURCE_IS_AXIS;
            speed         = RST_STEP_SPEED;
            centre_rate   = RST_CENTRE_RATE;
            relative_mode = RST_RELATIVE_OUTPUT;
            gain          = RST_OUTPUT_GAIN;
            slider_pos    = CENTRE_POS;
            errors        = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOURCE_IS_AXIS:  axis_mode     = cfg_data[0];
                    REG_STEP_SPEED:      speed         = cfg_data;
                    REG_CENTRE_RATE:     centre_rate   = cfg_data[7:0];
                    REG_RELATIVE_OUTPUT: relative_mode = cfg_data[0];
                    REG_OUTPUT_GAIN:     gain          = cfg_data[9:0];
                    default:             ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $error("result with no item pending: position %h game_value %h",
                           out_data.position, out_data.game_value);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.position !== want.position)
                    begin
                        errors++;
                        $error("position: expected %h, got %h",
                               want.position, out_data.position);
                    end
                    if (out_data.game_value !== want.game_value)
                    begin
                        errors++;
                        $error("game_value: expected %h, got %h",
                               want.game_value, out_data.game_value);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want       = advance_slider(in_data);
                slider_pos = want.position;
                expected_q = {expected_q, want};
            end
        end
        mismatch_count <= errors;
        expected_left  <= expected_q.size();
    end

endmodule

@@ sim/tb_digital_to_analog_slider_core.sv @@
`timescale 1ns / 100ps
// testbench top: drives items, settings and output stalls around the slider core
module tb_digital_to_analog_slider_core;
    import dtas_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_PHASES    = 17;
    localparam int ITEMS_PER_PHASE  = 100;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    dtas_in_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    dtas_out_t              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     mismatch_count;
    int                     expected_left;
    int                     items_sent  = 0;
    int                     phase_count = 0;
    int                     burst_left  = 0;
    int                     stall_left  = 0;
    int                     stall_mode  = 0;
    int                     mode_cycles = 0;

    digital_to_analog_slider_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dtas_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        mode_cycles++;
        if (mode_cycles >= 400)
        begin
            mode_cycles = 0;
            stall_mode  = $urandom_range(0, 2);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: out_ready <= 1'b1;
                1:
                begin
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 40);
                    out_ready <= (stall_left == 0);
                end
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic send_item(input logic dec, input logic inc, input logic [15:0] axis);
        dtas_in_t item;
        item.key_decrease = dec;
        item.key_increase = inc;
        item.axis_sample  = axis;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 4);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        phase_count++;
    endtask

    task automatic random_settings();
        logic [15:0] speed_val;
        logic [7:0]  centre_val;
        logic [9:0]  gain_val;
        case ($urandom_range(0, 5))
            0:       speed_val = 16'd0;
            1:       speed_val = 16'hFFFF;
            2:       speed_val = 16'd256;
            3:       speed_val = 16'($urandom_range(1, 4096));
            default: speed_val = 16'($urandom());
        endcase
        case ($urandom_range(0, 5))
            0:       centre_val = 8'd0;
            1:       centre_val = 8'd1;
            2:       centre_val = 8'd2;
            3:       centre_val = 8'd255;
            4:       centre_val = 8'($urandom_range(2, 16));
            default: centre_val = 8'($urandom());
        endcase
        case ($urandom_range(0, 4))
            0:       gain_val = 10'd0;
            1:       gain_val = 10'd1023;
            2:       gain_val = 10'd256;
            default: gain_val = 10'($urandom());
        endcase
        write_reg(REG_SOURCE_IS_AXIS, 16'($urandom()));
        write_reg(REG_STEP_SPEED, speed_val);
        write_reg(REG_CENTRE_RATE, {8'($urandom()), centre_val});
        write_reg(REG_RELATIVE_OUTPUT, 16'($urandom()));
        write_reg(REG_OUTPUT_GAIN, {6'($urandom()), gain_val});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(5, 7)), 16'($urandom()));
    endtask

    task automatic random_run(input int count);
        int          run_left;
        int          key_kind;
        int          axis_kind;
        logic        dec;
        logic        inc;
        logic [15:0] axis;
        run_left  = 0;
        key_kind  = 0;
        axis_kind = 0;
        for (int n = 0; n < count; n++)
        begin
            if (run_left == 0)
            begin
                run_left  = $urandom_range(1, 30);
                key_kind  = $urandom_range(0, 4);
                axis_kind = $urandom_range(0, 4);
            end
            run_left--;
            case (key_kind)
                0:       {dec, inc} = 2'b00;
                1:       {dec, inc} = 2'b01;
                2:       {dec, inc} = 2'b10;
                3:       {dec, inc} = 2'b11;
                default: {dec, inc} = 2'($urandom());
            endcase
            case (axis_kind)
                0:       axis = 16'd0;
                1:       axis = 16'($urandom());
                2:       axis = 16'($urandom_range(0, 600) - 300);
                3:       axis = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default: axis = ($urandom_range(0, 1) ? 16'h4000 : 16'hC000)
                                + 16'($urandom_range(0, 255));
            endcase
            send_item(dec, inc, axis);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset: keys, seven-fold speed, no centring
        send_item(1'b0, 1'b1, 16'h0000);
        send_item(1'b1, 1'b0, 16'hFFFF);
        send_item(1'b1, 1'b1, 16'h0000);
        send_item(1'b0, 1'b0, 16'h0000);
        settle();

        // full speed saturates both ends, snap to centre when idle
        write_reg(REG_STEP_SPEED, 16'hFFFF);
        write_reg(REG_CENTRE_RATE, 16'd1);
        send_item(1'b0, 1'b1, 16'h8000);
        send_item(1'b0, 1'b0, 16'h7FFF);
        send_item(1'b1, 1'b0, 16'h0000);
        send_item(1'b1, 1'b1, 16'h0000);
        send_item(1'b0, 1'b0, 16'h0000);
        settle();

        // axis source, decay to two thirds, relative output at top gain
        write_reg(REG_SOURCE_IS_AXIS, 16'd1);
        write_reg(REG_CENTRE_RATE, 16'd3);
        write_reg(REG_RELATIVE_OUTPUT, 16'd1);
        write_reg(REG_OUTPUT_GAIN, 16'd1023);
        send_item(1'b0, 1'b0, 16'h7FFF);
        send_item(1'b1, 1'b1, 16'h0000);
        send_item(1'b0, 1'b0, 16'h8000);
        send_item(1'b0, 1'b0, 16'h0000);
        send_item(1'b0, 1'b0, 16'h0001);
        send_item(1'b1, 1'b0, 16'hFFFF);
        send_item(1'b0, 1'b1, 16'd127);
        send_item(1'b0, 1'b0, 16'hFF7F);
        settle();

        // absolute output clipped high, slowest speed, slow decay, masked writes
        write_reg(REG_SOURCE_IS_AXIS, 16'hFFFE);
        write_reg(REG_RELATIVE_OUTPUT, 16'h0000);
        write_reg(REG_STEP_SPEED, 16'd1);
        write_reg(REG_CENTRE_RATE, 16'hFFFF);
        write_reg(REG_OUTPUT_GAIN, 16'hFFFF);
        write_reg(REG_UNUSED, 16'h1234);
        send_item(1'b0, 1'b1, 16'h0000);
        send_item(1'b0, 1'b0, 16'h0000);
        send_item(1'b1, 1'b0, 16'h0000);
        settle();
        write_reg(REG_OUTPUT_GAIN, 16'd0);
        send_item(1'b0, 1'b1, 16'h0000);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_settings();
            random_run(ITEMS_PER_PHASE);
            settle();
        end

        $display("covered %0d items over %0d setting phases: key and axis sources,",
                 items_sent, phase_count);
        $display("saturation, snap and decay centring, relative and clipped output");
        if (expected_left != 0)
            $error("%0d results never arrived", expected_left);
        if (mismatch_count == 0 && expected_left == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
